// ===== rtl/core/pus_pkg.sv =====
// ----------------------------------------------------------------------------
// pus_pkg
// Shared types and codes for the piecewise uniform sampler: operation and
// status codes, register indexes and the request words of the arithmetic units.
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int MUL_W = 96;
  localparam int DIV_W = 64;

  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_INSERT    = 3'd1;
  localparam logic [2:0] OP_NORMALIZE = 3'd2;
  localparam logic [2:0] OP_SAMPLE    = 3'd3;
  localparam logic [2:0] OP_EVALUATE  = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_RANGE      = 3'd2;
  localparam logic [2:0] ST_NOT_NORM   = 3'd3;
  localparam logic [2:0] ST_ZERO_MASS  = 3'd4;
  localparam logic [2:0] ST_ALREADY    = 3'd5;

  localparam logic [1:0] REG_RANGE_LOW     = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH    = 2'd1;
  localparam logic [1:0] REG_FIRST_WEIGHT  = 2'd2;
  localparam logic [1:0] REG_SEGMENT_LIMIT = 2'd3;

  typedef struct packed {
    logic             start;
    logic [63:0]      a;
    logic [63:0]      b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/core/pus_ram.sv =====
// ----------------------------------------------------------------------------
// pus_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pus_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pus_mul.sv =====
// ----------------------------------------------------------------------------
// pus_mul
// Sequential 64 x 64 multiplier built on one 32 x 32 multiplier. It forms
// a_lo*b_lo + (a_lo*b_hi + a_hi*b_lo) << 32, which is the exact product when
// a is below 2^32 and gives the correct low 64 bits otherwise.
// ----------------------------------------------------------------------------
module pus_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  pus_pkg::mul_req_t         req,
  output logic                      done,
  output logic [pus_pkg::MUL_W-1:0] prod
);

  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] p;
  logic [2:0]  phase;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mprod;

  always_comb begin
    ma = ra[31:0];
    mb = rb[31:0];
    case (phase)
      3'd2:    mb = rb[63:32];
      3'd3:    ma = ra[63:32];
      default: ;
    endcase
  end

  assign mprod = 64'(ma) * 64'(mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 3'd0;
      done  <= 1'b0;
    end else begin
      done <= !req.start && (phase == 3'd4);
      if (req.start) begin
        ra    <= req.a;
        rb    <= req.b;
        phase <= 3'd1;
      end else begin
        case (phase)
          3'd1: begin
            p     <= mprod;
            phase <= 3'd2;
          end
          3'd2: begin
            prod  <= pus_pkg::MUL_W'(p);
            p     <= mprod;
            phase <= 3'd3;
          end
          3'd3: begin
            prod  <= prod + (pus_pkg::MUL_W'(p) << 32);
            p     <= mprod;
            phase <= 3'd4;
          end
          3'd4: begin
            prod  <= prod + (pus_pkg::MUL_W'(p) << 32);
            phase <= 3'd0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/pus_div.sv =====
// ----------------------------------------------------------------------------
// pus_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pus_div (
  input  logic                      clk,
  input  logic                      rst,
  input  pus_pkg::div_req_t         req,
  output logic                      done,
  output logic [pus_pkg::DIV_W-1:0] quot
);

  localparam int DW = pus_pkg::DIV_W;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          fits;

  assign rem_sh  = {rem, quot[DW-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !req.start && (cnt == CW'(1));
      if (req.start) begin
        quot <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= CW'(DW);
      end else if (cnt != '0) begin
        rem  <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quot <= {quot[DW-2:0], fits};
        cnt  <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/piecewise_uniform_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_uniform_sampler_unit
// Piecewise-constant density with inverse-CDF sampling. Boundaries, weights
// and the cumulative table live in three synchronous memories.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   operation, point, weight, uniform
//   out      out_valid / out_ready status, sample, density, cumulative
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One word is worked at a time; the memories are read one entry per cycle.
// Clear and rejected items go straight to the result; an insert moves the
// entries above the new point, a normalize makes two passes over the segments
// around a 64-step reciprocal divide, and a sample or evaluate searches the
// segments before its arithmetic. A waiting result does not block taking the
// next word, only its completion. Reset empties the table to one segment and
// clears the normalize flag.
// ----------------------------------------------------------------------------
module piecewise_uniform_sampler_unit #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] point,
  input  logic [15:0]        weight,
  input  logic [31:0]        uniform,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] sample,
  output logic [31:0]        density,
  output logic [32:0]        cumulative,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW   = $clog2(MAX_SEGMENTS + 1);
  localparam int WAW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CMPW = (AW > 7) ? AW : 7;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic [29:0] {
    S_IDLE    = 30'd1 << 0,
    S_INS_RD  = 30'd1 << 1,
    S_INS_CMP = 30'd1 << 2,
    S_INS_PUT = 30'd1 << 3,
    S_NRM_W0  = 30'd1 << 4,
    S_NRM_WN  = 30'd1 << 5,
    S_NRM_RD  = 30'd1 << 6,
    S_NRM_DAT = 30'd1 << 7,
    S_NRM_MUL = 30'd1 << 8,
    S_NRM_MWT = 30'd1 << 9,
    S_NRM_ACC = 30'd1 << 10,
    S_NRM_CHK = 30'd1 << 11,
    S_NRM_DIV = 30'd1 << 12,
    S_NRM_END = 30'd1 << 13,
    S_SMP_RD  = 30'd1 << 14,
    S_SMP_CMP = 30'd1 << 15,
    S_EVL_B0  = 30'd1 << 16,
    S_EVL_BN  = 30'd1 << 17,
    S_EVL_N   = 30'd1 << 18,
    S_EVL_RD  = 30'd1 << 19,
    S_EVL_CMP = 30'd1 << 20,
    S_SEG     = 30'd1 << 21,
    S_SEG2    = 30'd1 << 22,
    S_SEG3    = 30'd1 << 23,
    S_WR_WT   = 30'd1 << 24,
    S_SMP_DW  = 30'd1 << 25,
    S_SMP_FIN = 30'd1 << 26,
    S_EVL_M   = 30'd1 << 27,
    S_EVL_MW  = 30'd1 << 28,
    S_DONE    = 30'd1 << 29
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic [15:0]        first_weight;
  logic [6:0]         segment_limit;

  // Table state.
  logic [AW-1:0]      count;
  logic               flag;
  logic [63:0]        inv_mass;

  // Latched word and working registers.
  logic [2:0]         op;
  logic signed [31:0] x;
  logic [15:0]        wt;
  logic [31:0]        u;
  logic [AW-1:0]      idx;
  logic               pass2;
  logic [63:0]        total;
  logic [47:0]        prod;
  logic signed [31:0] bprev;
  logic [15:0]        wprev;
  logic signed [31:0] b0;
  logic signed [31:0] bn;
  logic signed [31:0] bs;
  logic signed [31:0] bs1;
  logic [15:0]        ws;
  logic [32:0]        cs;
  logic [63:0]        q;
  logic [47:0]        pw;

  // Staged result.
  logic [2:0]         st_status;
  logic [31:0]        st_sample;
  logic [31:0]        st_density;
  logic [32:0]        st_cum;

  // Memory ports.
  logic               b_we;
  logic [AW-1:0]      b_waddr;
  logic [31:0]        b_wdata;
  logic [AW-1:0]      b_raddr;
  logic signed [31:0] b_rd;
  logic               w_we;
  logic [WAW-1:0]     w_waddr;
  logic [15:0]        w_wdata;
  logic [WAW-1:0]     w_raddr;
  logic [15:0]        w_rd;
  logic               c_we;
  logic [AW-1:0]      c_waddr;
  logic [32:0]        c_wdata;
  logic [AW-1:0]      c_raddr;
  logic [32:0]        c_rd;

  pus_pkg::mul_req_t           mul_req;
  logic                        mul_done;
  logic [pus_pkg::MUL_W-1:0]   mul_res;
  pus_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [pus_pkg::DIV_W-1:0]   div_quot;

  // Derived values.
  logic [AW-1:0]      idx_m1;
  logic [AW:0]        idx_p1;
  logic               last_seg;
  logic [WAW-1:0]     w_idx;
  logic [CMPW-1:0]    lim;
  logic               full;
  logic signed [32:0] nrm_diff;
  logic [31:0]        nrm_width;
  logic signed [32:0] seg_diff;
  logic [31:0]        seg_width;
  logic signed [32:0] ev_diff;
  logic [31:0]        ev_dx;
  logic [31:0]        smp_dx;
  logic [33:0]        cum_sum;
  logic               smp_div_go;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign idx_m1   = idx - AW'(1);
  assign idx_p1   = {1'b0, idx} + (AW + 1)'(1);
  assign last_seg = idx_p1 >= {1'b0, count};
  assign w_idx    = (idx < AW'(MAX_SEGMENTS)) ? idx[WAW-1:0] : '0;

  assign lim  = (CMPW'(segment_limit) < CMPW'(MAX_SEGMENTS)) ?
                CMPW'(segment_limit) : CMPW'(MAX_SEGMENTS);
  assign full = CMPW'(count) >= lim;

  // A negative segment width counts as zero.
  assign nrm_diff  = 33'(b_rd) - 33'(bprev);
  assign nrm_width = nrm_diff[32] ? 32'd0 : nrm_diff[31:0];
  assign seg_diff  = 33'(bs1) - 33'(bs);
  assign seg_width = seg_diff[32] ? 32'd0 : seg_diff[31:0];
  assign ev_diff   = 33'(x) - 33'(bs);
  assign ev_dx     = ev_diff[32] ? 32'd0 :
                     ((ev_diff[31:0] > seg_width) ? seg_width : ev_diff[31:0]);
  assign smp_dx    = (q > 64'(seg_width)) ? seg_width : q[31:0];
  assign cum_sum   = {1'b0, cs} + 34'(mul_res[63:32]);

  assign smp_div_go = (ws != 16'd0) && ({1'b0, u} > cs) && (mul_res[95:64] == 32'd0);

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = total;
    mul_req.b     = inv_mass;
    case (state)
      S_NRM_MUL: mul_req.start = 1'b1;
      S_SEG3: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(ws);
      end
      S_EVL_M: begin
        mul_req.start = 1'b1;
        mul_req.a     = 64'(pw);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '1;
    div_req.den   = total;
    case (state)
      S_NRM_CHK: div_req.start = (total != 64'd0);
      S_WR_WT: begin
        div_req.start = mul_done && (op == pus_pkg::OP_SAMPLE) && smp_div_go;
        div_req.num   = {u - cs[31:0], 32'd0};
        div_req.den   = mul_res[63:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    b_we    = 1'b0;
    b_waddr = idx;
    b_wdata = x;
    b_raddr = idx;
    w_we    = 1'b0;
    w_waddr = w_idx;
    w_wdata = wt;
    w_raddr = w_idx;
    c_we    = 1'b0;
    c_waddr = idx_m1;
    c_wdata = {1'b0, mul_res[63:32]};
    c_raddr = idx;
    case (state)
      S_INS_RD: begin
        b_raddr = idx_m1;
        w_raddr = idx_m1[WAW-1:0];
      end
      S_INS_CMP: begin
        // Move the entry below up by one, weight together with its boundary.
        b_we    = (x <= b_rd);
        b_wdata = b_rd;
        w_we    = (x <= b_rd);
        w_wdata = w_rd;
      end
      S_INS_PUT: begin
        b_we = 1'b1;
        w_we = 1'b1;
      end
      S_NRM_W0: begin
        b_we    = 1'b1;
        b_waddr = '0;
        b_wdata = range_low;
        w_we    = 1'b1;
        w_waddr = '0;
        w_wdata = first_weight;
      end
      S_NRM_WN: begin
        b_we    = 1'b1;
        b_waddr = count;
        b_wdata = range_high;
      end
      S_NRM_MWT: c_we = mul_done;
      S_NRM_END: begin
        c_we    = 1'b1;
        c_waddr = count;
        c_wdata = ONE_Q32;
      end
      S_SMP_RD: c_raddr = idx_p1[AW-1:0];
      S_EVL_B0: b_raddr = '0;
      S_EVL_BN: b_raddr = count;
      S_EVL_RD: b_raddr = idx_p1[AW-1:0];
      S_SEG2:   b_raddr = idx_p1[AW-1:0];
      default: ;
    endcase
  end

  pus_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS + 1)) u_bnd (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rd)
  );

  pus_ram #(.WIDTH(16), .DEPTH(MAX_SEGMENTS)) u_wgt (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rd)
  );

  pus_ram #(.WIDTH(33), .DEPTH(MAX_SEGMENTS + 1)) u_cum (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rd)
  );

  pus_mul u_mul (
    .clk(clk), .rst(rst), .req(mul_req), .done(mul_done), .prod(mul_res)
  );

  pus_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low     <= 32'sd0;
      range_high    <= 32'sd65536;
      first_weight  <= 16'd1;
      segment_limit <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pus_pkg::REG_RANGE_LOW:     range_low     <= cfg_data;
        pus_pkg::REG_RANGE_HIGH:    range_high    <= cfg_data;
        pus_pkg::REG_FIRST_WEIGHT:  first_weight  <= cfg_data[15:0];
        pus_pkg::REG_SEGMENT_LIMIT: segment_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= AW'(1);
      flag      <= 1'b0;
      inv_mass  <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      // A word that leaves while the next one is loaded is handled in S_DONE.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= operation;
            x          <= point;
            wt         <= weight;
            u          <= uniform;
            st_sample  <= 32'd0;
            st_density <= 32'd0;
            st_cum     <= 33'd0;
            case (operation)
              pus_pkg::OP_CLEAR: begin
                count     <= AW'(1);
                flag      <= 1'b0;
                inv_mass  <= 64'd0;
                st_status <= pus_pkg::ST_OK;
                idx       <= '0;
                state     <= S_DONE;
              end
              pus_pkg::OP_INSERT: begin
                idx <= count;
                if (flag) begin
                  st_status <= pus_pkg::ST_ALREADY;
                  state     <= S_DONE;
                end else if (full) begin
                  st_status <= pus_pkg::ST_FULL;
                  state     <= S_DONE;
                end else if (point < range_low || point > range_high) begin
                  st_status <= pus_pkg::ST_RANGE;
                  state     <= S_DONE;
                end else begin
                  st_status <= pus_pkg::ST_OK;
                  state     <= S_INS_RD;
                end
              end
              pus_pkg::OP_NORMALIZE: begin
                st_status <= pus_pkg::ST_OK;
                idx       <= '0;
                state     <= S_NRM_W0;
              end
              pus_pkg::OP_SAMPLE, pus_pkg::OP_EVALUATE: begin
                idx <= '0;
                if (!flag || inv_mass == 64'd0) begin
                  st_status <= pus_pkg::ST_NOT_NORM;
                  state     <= S_DONE;
                end else begin
                  st_status <= pus_pkg::ST_OK;
                  state <= (operation == pus_pkg::OP_SAMPLE) ? S_SMP_RD : S_EVL_B0;
                end
              end
              default: begin
                st_status <= pus_pkg::ST_OK;
                idx       <= '0;
                state     <= S_DONE;
              end
            endcase
          end
        end
        // Insert walks down from the top, moving every entry not below the
        // new point up by one slot.
        S_INS_RD: state <= (idx == AW'(1)) ? S_INS_PUT : S_INS_CMP;
        S_INS_CMP: begin
          if (x <= b_rd) begin
            idx   <= idx_m1;
            state <= S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          count <= count + AW'(1);
          state <= S_DONE;
        end
        S_NRM_W0: state <= S_NRM_WN;
        S_NRM_WN: begin
          idx   <= '0;
          total <= 64'd0;
          pass2 <= 1'b0;
          state <= S_NRM_RD;
        end
        S_NRM_RD: state <= S_NRM_DAT;
        S_NRM_DAT: begin
          bprev <= b_rd;
          wprev <= w_rd;
          if (idx == '0) begin
            idx   <= AW'(1);
            state <= S_NRM_RD;
          end else begin
            prod  <= 48'(wprev) * 48'(nrm_width);
            state <= pass2 ? S_NRM_MUL : S_NRM_ACC;
          end
        end
        S_NRM_MUL: state <= S_NRM_MWT;
        S_NRM_MWT: begin
          if (mul_done) begin
            state <= S_NRM_ACC;
          end
        end
        S_NRM_ACC: begin
          total <= total + 64'(prod);
          if (idx == count) begin
            state <= pass2 ? S_NRM_END : S_NRM_CHK;
          end else begin
            idx   <= idx_p1[AW-1:0];
            state <= S_NRM_RD;
          end
        end
        S_NRM_CHK: begin
          if (total == 64'd0) begin
            flag      <= 1'b0;
            inv_mass  <= 64'd0;
            st_status <= pus_pkg::ST_ZERO_MASS;
            state     <= S_DONE;
          end else begin
            state <= S_NRM_DIV;
          end
        end
        // The second pass rebuilds the running mass and scales it.
        S_NRM_DIV: begin
          if (div_done) begin
            inv_mass <= div_quot;
            total    <= 64'd0;
            idx      <= '0;
            pass2    <= 1'b1;
            state    <= S_NRM_RD;
          end
        end
        S_NRM_END: begin
          flag  <= 1'b1;
          state <= S_DONE;
        end
        S_SMP_RD: state <= last_seg ? S_SEG : S_SMP_CMP;
        S_SMP_CMP: begin
          if ({1'b0, u} <= c_rd) begin
            state <= S_SEG;
          end else begin
            idx   <= idx_p1[AW-1:0];
            state <= S_SMP_RD;
          end
        end
        S_EVL_B0: state <= S_EVL_BN;
        S_EVL_BN: begin
          b0    <= b_rd;
          state <= S_EVL_N;
        end
        S_EVL_N: begin
          bn    <= b_rd;
          state <= S_EVL_RD;
        end
        S_EVL_RD: state <= last_seg ? S_SEG : S_EVL_CMP;
        S_EVL_CMP: begin
          if (x <= b_rd) begin
            state <= S_SEG;
          end else begin
            idx   <= idx_p1[AW-1:0];
            state <= S_EVL_RD;
          end
        end
        S_SEG: state <= S_SEG2;
        S_SEG2: begin
          bs    <= b_rd;
          ws    <= w_rd;
          cs    <= c_rd;
          state <= S_SEG3;
        end
        S_SEG3: begin
          bs1   <= b_rd;
          state <= S_WR_WT;
        end
        // The product weight times reciprocal is ready here.
        S_WR_WT: begin
          if (mul_done) begin
            if (op == pus_pkg::OP_SAMPLE) begin
              if (ws == 16'd0) begin
                st_sample <= bs;
                state     <= S_DONE;
              end else if (smp_div_go) begin
                state <= S_SMP_DW;
              end else begin
                q     <= 64'd0;
                state <= S_SMP_FIN;
              end
            end else begin
              if (x > b0 && x <= bn) begin
                st_density <= (mul_res[79:64] != 16'd0) ? 32'hFFFF_FFFF : mul_res[63:32];
              end
              if (x <= b0) begin
                state <= S_DONE;
              end else if (x >= bn) begin
                st_cum <= ONE_Q32;
                state  <= S_DONE;
              end else begin
                pw    <= 48'(ws) * 48'(ev_dx);
                state <= S_EVL_M;
              end
            end
          end
        end
        S_SMP_DW: begin
          if (div_done) begin
            q     <= div_quot;
            state <= S_SMP_FIN;
          end
        end
        S_SMP_FIN: begin
          st_sample <= bs + smp_dx;
          state     <= S_DONE;
        end
        S_EVL_M: state <= S_EVL_MW;
        S_EVL_MW: begin
          if (mul_done) begin
            st_cum <= (cum_sum > 34'(ONE_Q32)) ? ONE_Q32 : cum_sum[32:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status     <= st_status;
            sample     <= st_sample;
            density    <= st_density;
            cumulative <= st_cum;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/pus_chk.sv =====
// ----------------------------------------------------------------------------
// pus_chk
// Port-level checks for the sampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pus_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] sample,
  input logic [31:0] density,
  input logic [32:0] cumulative
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(status) && $stable(sample))
    else $error("stalled result word changed");

  // One word at a time: the block is busy right after it takes a word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != pus_pkg::ST_OK |->
      sample == 32'd0 && density == 32'd0 && cumulative == 33'd0)
    else $error("failed operation returned nonzero data");

  a_cum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cumulative <= 33'h1_0000_0000 && status <= pus_pkg::ST_ALREADY)
    else $error("cumulative above one or status code out of range");

endmodule

bind piecewise_uniform_sampler_unit pus_chk u_pus_chk (.*);
